// ===== rtl/htw_pkg.sv =====
// Package with shared types and constants of the timer wheel.
`default_nettype none
package htw_pkg;
   localparam int TimerCountDefault = 32;
   localparam logic [15:0] PeriodReset = 16'd1000;
   localparam logic [21:0] DelayLimit = 22'd2678400;
   localparam logic [16:0] SecsDay = 17'd86400;
   localparam logic [5:0] SecSlots = 6'd60;
   localparam logic [5:0] MinSlots = 6'd60;
   localparam logic [5:0] HourSlots = 6'd24;
   localparam logic [5:0] DaySlots = 6'd30;

   typedef enum logic [1:0] {
      EV_INSERT = 2'd0,
      EV_EXPIRE = 2'd1,
      EV_TICK   = 2'd2
   } event_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_SPLIT,
      ST_INS_PLACE,
      ST_INS_DONE,
      ST_INS_EXP,
      ST_TICK_CHK,
      ST_SCAN_RD,
      ST_SCAN_SPLIT,
      ST_SCAN_PLACE,
      ST_SCAN_NEXT,
      ST_TICK_DONE,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_req;
      logic        split;
      logic        place;
      logic        check_tick;
      logic        turn_start;
      logic        scan_read;
      logic        scan_split;
      logic        scan_place;
      logic        scan_next;
      logic [1:0]  emit_event;
      logic        emit_status;
      logic        emit_last;
      logic        emit_from_scan;
      logic        emit_valid;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic too_long;
      logic id_out;
      logic zero_delay;
      logic do_turn;
      logic hit;
      logic hit_expires;
      logic scan_end;
      logic more_levels;
      logic out_busy;
   } stat_type;
endpackage
`default_nettype wire

// ===== rtl/htw_if.sv =====
// Valid and ready channel interfaces for requests and results.
`default_nettype none
interface htw_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [4:0]  timer_id;
   logic [21:0] delay_seconds;
   logic [62:0] now_ms;
   modport source (output valid, kind, timer_id, delay_seconds, now_ms, input ready);
   modport sink (input valid, kind, timer_id, delay_seconds, now_ms, output ready);
endinterface

interface htw_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_res;
   logic [4:0] timer_id_res;
   logic       status;
   logic       last;
   modport source (output valid, event_res, timer_id_res, status, last, input ready);
   modport sink (input valid, event_res, timer_id_res, status, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/htw_ctrl.sv =====
// Controller state machine that sequences inserts, ticks and wheel scans.
`default_nettype none
module htw_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire htw_pkg::stat_type stat,
   output htw_pkg::cmd_type       cmd
);
   import htw_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_INS_SPLIT;
            end
         end
         ST_INS_SPLIT: begin
            if (stat.is_tick) begin
               state_in = ST_TICK_CHK;
            end else begin
               cmd.split = 1'b1;
               state_in = ST_INS_PLACE;
            end
         end
         ST_INS_PLACE: begin
            if (!stat.too_long && !stat.id_out) cmd.place = 1'b1;
            state_in = ST_INS_DONE;
         end
         ST_INS_DONE: begin
            if (!stat.out_busy) begin
               cmd.emit_valid  = 1'b1;
               cmd.emit_event  = EV_INSERT;
               cmd.emit_status = stat.too_long;
               cmd.emit_last   = !(stat.zero_delay && !stat.too_long && !stat.id_out);
               state_in = cmd.emit_last ? ST_IDLE : ST_INS_EXP;
            end
         end
         ST_INS_EXP: begin
            if (!stat.out_busy) begin
               cmd.emit_valid = 1'b1;
               cmd.emit_event = EV_EXPIRE;
               cmd.emit_last  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_TICK_CHK: begin
            cmd.check_tick = 1'b1;
            if (stat.do_turn) begin
               cmd.turn_start = 1'b1;
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_TICK_DONE;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in = ST_SCAN_SPLIT;
         end
         ST_SCAN_SPLIT: begin
            if (stat.hit) begin
               cmd.scan_split = 1'b1;
               state_in = ST_SCAN_PLACE;
            end else begin
               state_in = ST_SCAN_NEXT;
            end
         end
         ST_SCAN_PLACE: begin
            cmd.scan_place = 1'b1;
            if (stat.hit_expires) begin
               state_in = ST_EMIT;
               ret_in = ST_SCAN_NEXT;
            end else begin
               state_in = ST_SCAN_NEXT;
            end
         end
         ST_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit_valid     = 1'b1;
               cmd.emit_event     = EV_EXPIRE;
               cmd.emit_from_scan = 1'b1;
               state_in = ret_ff;
            end
         end
         ST_SCAN_NEXT: begin
            cmd.scan_next = 1'b1;
            if (!stat.scan_end) state_in = ST_SCAN_RD;
            else if (stat.more_levels) state_in = ST_SCAN_RD;
            else state_in = ST_TICK_DONE;
         end
         ST_TICK_DONE: begin
            if (!stat.out_busy) begin
               cmd.emit_valid = 1'b1;
               cmd.emit_event = EV_TICK;
               cmd.emit_last  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/htw_dp.sv =====
// Datapath with timer table, wheel positions, tick timing and result register.
`default_nettype none
module htw_dp #(
   parameter int TIMER_COUNT = htw_pkg::TimerCountDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_kind,
   input  wire logic [4:0]        req_timer_id,
   input  wire logic [21:0]       req_delay_seconds,
   input  wire logic [62:0]       req_now_ms,
   input  wire logic              csr_we,
   input  wire logic [15:0]       csr_wdata,
   input  wire htw_pkg::cmd_type  cmd,
   output htw_pkg::stat_type      stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_event_res,
   output logic [4:0]             rsp_timer_id_res,
   output logic                   rsp_status,
   output logic                   rsp_last
);
   import htw_pkg::*;

   localparam int IdW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   // Reciprocals, rounded up, for the constant divisions of the delay split.
   // Hours divide the delay over 16 by 225, days the delay over 128 by 675.
   localparam logic [12:0] RecipMin  = 13'd4370;
   localparam logic [12:0] RecipHour = 13'd4661;
   localparam logic [14:0] RecipDay  = 15'd24856;

   // Timer table: valid, level, slot and remainder per entry.
   logic [TIMER_COUNT-1:0] valid_ff, valid_in;
   logic [1:0]  level_ff [TIMER_COUNT];
   logic [5:0]  slot_ff  [TIMER_COUNT];
   logic [16:0] rem_ff   [TIMER_COUNT];

   logic [5:0]  sec_pos_ff, min_pos_ff, hour_pos_ff, day_pos_ff;
   logic [16:0] tick_count_ff, tick_count_in;
   logic [63:0] last_turn_ff;
   logic [15:0] period_ff;

   logic        kind_ff;
   logic [4:0]  id_ff;
   logic [21:0] delay_ff;
   logic [62:0] now_ff;

   // Split unit: delay, level and quotient by one wheel unit.
   logic [21:0] sp_val_ff;
   logic [1:0]  sp_level_ff;
   logic [5:0]  sp_q_ff;
   logic        sp_zero_ff;

   // Turn scan state.
   logic [1:0]  lvl_ff;
   logic [5:0]  front_ff;
   logic [IdW-1:0] scan_ff;
   logic        m_turn_ff, h_turn_ff, d_turn_ff;
   logic        hit_ff;

   logic [1:0]  ev_ff;
   logic [4:0]  oid_ff;
   logic        ost_ff, olast_ff, ovalid_ff;

   logic [IdW-1:0] place_id;
   logic [5:0]  place_pos, place_slots, slot_sum;
   logic [6:0]  slot_raw;
   logic [1:0]  lv;
   logic [5:0]  q;
   logic [21:0] dv;
   logic [24:0] prod_min;
   logic [25:0] prod_hour;
   logic [29:0] prod_day;
   logic [21:0] unit_mul, rem_full;
   logic [16:0] place_rem;
   logic [63:0] now_eff, elapsed;
   logic        turn_ok;
   logic        m_wrap, h_wrap, d_wrap;
   logic [IdW-1:0] id_trunc;

   assign id_trunc = IdW'(id_ff);
   assign now_eff  = (last_turn_ff == 64'd0) ? {1'b0, now_ff} : last_turn_ff;
   assign elapsed  = {1'b0, now_ff} - now_eff;
   assign turn_ok  = ({1'b0, now_ff} >= now_eff) && (elapsed >= {48'd0, period_ff});

   // Delay split: level and quotient by reciprocal multiplication.
   always_comb begin
      dv = cmd.scan_split ? {5'd0, rem_ff[scan_ff]} : delay_ff;
      prod_min  = {13'd0, dv[11:0]} * {12'd0, RecipMin};
      prod_hour = {13'd0, dv[16:4]} * {13'd0, RecipHour};
      prod_day  = {15'd0, dv[21:7]} * {15'd0, RecipDay};
      if (dv < 22'd60) begin
         lv = 2'd0; q = dv[5:0];
      end else if (dv < 22'd3600) begin
         lv = 2'd1; q = prod_min[23:18];
      end else if (dv < 22'd86400) begin
         lv = 2'd2; q = {1'b0, prod_hour[24:20]};
      end else begin
         lv = 2'd3; q = prod_day[29:24];
      end
   end

   // Remainder below the chosen wheel's unit, from the registered quotient.
   always_comb begin
      case (sp_level_ff)
         2'd1: unit_mul = {16'd0, sp_q_ff} * 22'd60;
         2'd2: unit_mul = {16'd0, sp_q_ff} * 22'd3600;
         2'd3: unit_mul = {16'd0, sp_q_ff} * 22'd86400;
         default: unit_mul = {16'd0, sp_q_ff};
      endcase
      rem_full  = sp_val_ff - unit_mul;
      place_rem = rem_full[16:0];
   end

   // Slot for a placement: (position + quotient - 1) mod wheel size.
   always_comb begin
      case (sp_level_ff)
         2'd0: begin place_pos = sec_pos_ff;  place_slots = SecSlots;  end
         2'd1: begin place_pos = min_pos_ff;  place_slots = MinSlots;  end
         2'd2: begin place_pos = hour_pos_ff; place_slots = HourSlots; end
         default: begin place_pos = day_pos_ff; place_slots = DaySlots; end
      endcase
      slot_raw = {1'b0, place_pos} + {1'b0, sp_q_ff} - 7'd1;
      slot_sum = (slot_raw >= {1'b0, place_slots}) ? 6'(slot_raw - {1'b0, place_slots})
                                                   : slot_raw[5:0];
      place_id = cmd.scan_place ? scan_ff : id_trunc;
   end

   assign tick_count_in = (tick_count_ff == SecsDay - 17'd1) ? 17'd0 : tick_count_ff + 17'd1;

   // The second position is the tick count mod 60 and the minute position counts
   // minutes mod 60, so their wraps mark the minute and hour turns.
   assign m_wrap = (sec_pos_ff == SecSlots - 6'd1);
   assign h_wrap = m_wrap && (min_pos_ff == MinSlots - 6'd1);
   assign d_wrap = (tick_count_in == 17'd0);

   always_comb begin
      valid_in = valid_ff;
      if ((cmd.place || cmd.scan_place) && sp_zero_ff) valid_in[place_id] = 1'b0;
      else if (cmd.place || (cmd.scan_place && lvl_ff != 2'd0)) valid_in[place_id] = 1'b1;
      else if (cmd.scan_place) valid_in[place_id] = 1'b0;
   end

   // Control state of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         sec_pos_ff    <= '0;
         min_pos_ff    <= '0;
         hour_pos_ff   <= '0;
         day_pos_ff    <= '0;
         tick_count_ff <= '0;
         last_turn_ff  <= '0;
         period_ff     <= PeriodReset;
         ovalid_ff     <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (csr_we) period_ff <= csr_wdata;
         if (cmd.check_tick) begin
            if (turn_ok) last_turn_ff <= {1'b0, now_ff};
            else last_turn_ff <= now_eff;
         end
         if (cmd.turn_start) begin
            tick_count_ff <= tick_count_in;
            sec_pos_ff <= (sec_pos_ff == SecSlots - 6'd1) ? 6'd0 : sec_pos_ff + 6'd1;
            if (m_wrap)
               min_pos_ff <= (min_pos_ff == MinSlots - 6'd1) ? 6'd0 : min_pos_ff + 6'd1;
            if (h_wrap)
               hour_pos_ff <= (hour_pos_ff == HourSlots - 6'd1) ? 6'd0 : hour_pos_ff + 6'd1;
            if (d_wrap)
               day_pos_ff <= (day_pos_ff == DaySlots - 6'd1) ? 6'd0 : day_pos_ff + 6'd1;
         end
         if (cmd.emit_valid) ovalid_ff <= 1'b1;
         else if (rsp_ready) ovalid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff  <= req_kind;
         id_ff    <= req_timer_id;
         delay_ff <= req_delay_seconds;
         now_ff   <= req_now_ms;
      end
      if (cmd.split || cmd.scan_split) begin
         sp_val_ff   <= dv;
         sp_level_ff <= lv;
         sp_q_ff     <= q;
         sp_zero_ff  <= (dv == 22'd0);
      end
      if (cmd.scan_read) begin
         hit_ff <= valid_ff[scan_ff] && level_ff[scan_ff] == lvl_ff
                   && slot_ff[scan_ff] == front_ff;
      end
      if (cmd.place || (cmd.scan_place && !sp_zero_ff && lvl_ff != 2'd0)) begin
         level_ff[place_id] <= sp_level_ff;
         slot_ff[place_id]  <= slot_sum;
         rem_ff[place_id]   <= place_rem;
      end
      if (cmd.turn_start) begin
         lvl_ff    <= 2'd0;
         front_ff  <= sec_pos_ff;
         scan_ff   <= '0;
         m_turn_ff <= m_wrap;
         h_turn_ff <= h_wrap;
         d_turn_ff <= d_wrap;
      end else if (cmd.scan_next) begin
         if (scan_ff == IdW'(TIMER_COUNT - 1)) begin
            scan_ff <= '0;
            if (lvl_ff == 2'd0 && m_turn_ff) begin
               lvl_ff <= 2'd1; front_ff <= (min_pos_ff == 6'd0) ? MinSlots - 6'd1
                                                                 : min_pos_ff - 6'd1;
            end else if (lvl_ff <= 2'd1 && h_turn_ff) begin
               lvl_ff <= 2'd2; front_ff <= (hour_pos_ff == 6'd0) ? HourSlots - 6'd1
                                                                  : hour_pos_ff - 6'd1;
            end else begin
               lvl_ff <= 2'd3; front_ff <= (day_pos_ff == 6'd0) ? DaySlots - 6'd1
                                                                : day_pos_ff - 6'd1;
            end
         end else begin
            scan_ff <= scan_ff + IdW'(1);
         end
      end
      if (cmd.emit_valid) begin
         ev_ff    <= cmd.emit_event;
         oid_ff   <= (cmd.emit_event == EV_TICK) ? 5'd0
                   : cmd.emit_from_scan ? 5'(scan_ff) : id_ff;
         ost_ff   <= cmd.emit_status;
         olast_ff <= cmd.emit_last;
      end
   end

   // Status to the controller: a scan hit at level 0 always expires, else when its split remainder is zero.
   always_comb begin
      stat.is_tick     = kind_ff;
      stat.too_long    = delay_ff >= DelayLimit;
      stat.id_out      = ({1'b0, id_ff} >= 6'(TIMER_COUNT));
      stat.zero_delay  = sp_zero_ff;
      stat.do_turn     = turn_ok;
      stat.hit         = hit_ff;
      stat.hit_expires = (lvl_ff == 2'd0) || sp_zero_ff;
      stat.scan_end    = (scan_ff == IdW'(TIMER_COUNT - 1));
      stat.more_levels = (lvl_ff == 2'd0 && (m_turn_ff || h_turn_ff || d_turn_ff))
                       || (lvl_ff == 2'd1 && (h_turn_ff || d_turn_ff))
                       || (lvl_ff == 2'd2 && d_turn_ff);
      stat.out_busy    = ovalid_ff && !rsp_ready;
   end

   assign rsp_valid        = ovalid_ff;
   assign rsp_event_res    = ev_ff;
   assign rsp_timer_id_res = oid_ff;
   assign rsp_status       = ost_ff;
   assign rsp_last         = olast_ff;
endmodule
`default_nettype wire

// ===== rtl/hierarchical_timer_wheel.sv =====
// Top level of the four-level timer wheel.
//
//  channel | direction | payload
//  req     | in        | kind, timer_id, delay_seconds, now_ms
//  rsp     | out       | event_res, timer_id_res, status, last
//  csr     | in        | tick_period_ms write (csr_we, csr_wdata)
//
// One request at a time. An insert goes through the split, place and done states,
// and an expire state as well with a zero delay; a tick that does not turn checks
// the tick and reports it. A turn reads and tests each table entry for each wheel
// scanned, places each timer found in a front slot and emits each expiry.
// Reset clears the valid bits, positions, tick count and last turn time, and sets
// the period to 1000 ms. A stalled result holds the sequencer in place.
`default_nettype none
module hierarchical_timer_wheel #(
   parameter int TIMER_COUNT = htw_pkg::TimerCountDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   htw_req_if.sink          req,
   htw_rsp_if.source        rsp,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   import htw_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   htw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   htw_dp #(.TIMER_COUNT(TIMER_COUNT)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_kind          (req.kind),
      .req_timer_id      (req.timer_id),
      .req_delay_seconds (req.delay_seconds),
      .req_now_ms        (req.now_ms),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp.valid),
      .rsp_ready         (rsp.ready),
      .rsp_event_res     (rsp.event_res),
      .rsp_timer_id_res  (rsp.timer_id_res),
      .rsp_status        (rsp.status),
      .rsp_last          (rsp.last)
   );
endmodule
`default_nettype wire

// ===== rtl/htw_checker.sv =====
// Port checker for the timer wheel, bound to the top level.
`default_nettype none
module htw_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_event_res,
   input wire logic       rsp_status,
   input wire logic       rsp_last
);
   import htw_pkg::*;

   // A result held back stays valid and keeps its event type.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res))
      else $error("stalled result changed");

   // A tick finished result always ends its request.
   a_tick_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_TICK |-> rsp_last)
      else $error("tick result not last");

   // Only inserts can be rejected.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_event_res == EV_INSERT && rsp_last)
      else $error("bad status");

   // No new request is taken right after one was accepted.
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back to back accept");
endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_event_res (rsp.event_res),
   .rsp_status    (rsp.status),
   .rsp_last      (rsp.last)
);
`default_nettype wire
